[design/assert_macros.svh]
// Assertion macros for the checker file of the button debouncer.
// Depends on signals named clk and rst_n in the scope that uses the macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

[design/bld_pkg.sv]
// Shared types, constants and functions of the button debouncer with event queue.
// Depends on nothing; every other design file but assert_macros.svh imports it.
package bld_pkg;

    localparam int PIN_W   = 3;
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int EVT_W   = 2;
    localparam int QCNT_W  = 5;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

    localparam logic [EVT_W-1:0] EVT_NONE     = 2'd0;
    localparam logic [EVT_W-1:0] EVT_PAGE     = 2'd1;
    localparam logic [EVT_W-1:0] EVT_TRIGGER0 = 2'd2;
    localparam logic [EVT_W-1:0] EVT_TRIGGER1 = 2'd3;

    typedef logic [EVT_W-1:0] evt_code_t;

    typedef struct packed {
        evt_code_t          event_code;
        logic [QCNT_W-1:0]  queued_count;
    } fifo_res_t;

    // Event code of a button: its index plus one, kept to two bits.
    function automatic evt_code_t bld_code(input int unsigned idx);
        logic [31:0] sum;
        begin
            sum = 32'(idx) + 32'd1;
            return sum[EVT_W-1:0];
        end
    endfunction

endpackage

[design/bld_if.sv]
// Valid/ready channel interfaces for input items and result words.
// Depends on bld_pkg for the field widths.
interface bld_in_if
    import bld_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PIN_W-1:0]    rising_edges;
    logic [PIN_W-1:0]    pin_levels;
    logic [TIME_W-1:0]   now_ms;
    logic                pop_request;

    modport source (output valid, output rising_edges, output pin_levels,
                    output now_ms, output pop_request, input ready);
    modport sink   (input valid, input rising_edges, input pin_levels,
                    input now_ms, input pop_request, output ready);
endinterface

interface bld_out_if
    import bld_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [EVT_W-1:0]    event_code;
    logic [QCNT_W-1:0]   queued_count;

    modport source (output valid, output event_code, output queued_count, input ready);
    modport sink   (input valid, input event_code, input queued_count, output ready);
endinterface

[design/bld_lane.sv]
// One button lane: lockout flag, last-high timestamp and debounce compare.
// Depends on bld_pkg.
module bld_lane
    import bld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               rise,
    input  logic               pin,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic [DEB_W-1:0]   debounce_ms,
    output logic               push_req
);

    logic               armed_reg;
    logic               armed_next;
    logic [TIME_W-1:0]  last_high_reg;
    logic [TIME_W-1:0]  last_high_next;
    logic [TIME_W-1:0]  elapsed;
    logic               armed_mid;

    assign push_req = rise & armed_reg;
    assign elapsed  = now_ms - last_high_reg;

    always_comb
    begin
        armed_mid      = armed_reg & ~rise;
        armed_next     = armed_mid;
        last_high_next = last_high_reg;
        if (!armed_mid)
        begin
            if (pin)
            begin
                last_high_next = now_ms;
            end
            else if (elapsed >= TIME_W'(debounce_ms))
            begin
                armed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b1;
            last_high_reg <= '0;
        end
        else if (en)
        begin
            armed_reg     <= armed_next;
            last_high_reg <= last_high_next;
        end
    end

endmodule

[design/bld_fifo.sv]
// Merging stage: event queue that takes the pushes of all lanes together, as far as there is room, and pops one word.
// Depends on bld_pkg.
module bld_fifo
    import bld_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int LANES = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [LANES-1:0]  push_req,
    input  logic              pop,
    output fifo_res_t         res
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 4;

    evt_code_t          store_reg [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [IW-1:0]      wr_idx_reg;
    logic [IW-1:0]      wr_idx_next;
    logic [IW-1:0]      rd_idx_reg;
    logic [IW-1:0]      rd_idx_next;

    logic [LANES-1:0]   acc;
    logic [IW-1:0]      slot [LANES];
    logic [SW-1:0]      rank;
    logic [SW-1:0]      taken;
    logic [SW-1:0]      pos;
    logic [SW-1:0]      total;
    logic [SW-1:0]      wr_sum;
    logic               pop_ok;
    evt_code_t          first_code;
    evt_code_t          code;

    always_comb
    begin
        rank       = '0;
        taken      = '0;
        first_code = EVT_NONE;
        for (int i = 0; i < LANES; i++)
        begin
            acc[i]  = 1'b0;
            slot[i] = '0;
            pos     = '0;
            if (push_req[i])
            begin
                if ((SW'(count_reg) + rank) < SW'(DEPTH))
                begin
                    acc[i] = 1'b1;
                    pos    = SW'(wr_idx_reg) + rank;
                    if (pos >= SW'(DEPTH))
                    begin
                        pos = pos - SW'(DEPTH);
                    end
                    slot[i] = pos[IW-1:0];
                    if (taken == '0)
                    begin
                        first_code = bld_code(i);
                    end
                    taken = taken + 1'b1;
                end
                rank = rank + 1'b1;
            end
        end

        total  = SW'(count_reg) + taken;
        pop_ok = pop && (total != '0);

        if (!pop_ok)
        begin
            code = EVT_NONE;
        end
        else if (count_reg != '0)
        begin
            code = store_reg[rd_idx_reg];
        end
        else
        begin
            code = first_code;
        end

        count_next = CW'(total - SW'(pop_ok));

        wr_sum = SW'(wr_idx_reg) + taken;
        if (wr_sum >= SW'(DEPTH))
        begin
            wr_sum = wr_sum - SW'(DEPTH);
        end
        wr_idx_next = wr_sum[IW-1:0];

        if (!pop_ok)
        begin
            rd_idx_next = rd_idx_reg;
        end
        else if (rd_idx_reg == IW'(DEPTH - 1))
        begin
            rd_idx_next = '0;
        end
        else
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
    end

    assign res.event_code   = code;
    assign res.queued_count = QCNT_W'(count_next);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (en && acc[i])
            begin
                store_reg[slot[i]] <= bld_code(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else if (en)
        begin
            count_reg  <= count_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

endmodule

[design/button_lockout_debounce_event_fifo.sv]
// Lockout debouncer for BUTTON_COUNT buttons with a FIFO_DEPTH-entry queue of press events.
// Each accepted item updates every button lane and the queue together and yields one
// result word, registered in the output register; the block takes one item per
// clock for as long as the result side keeps up, and stalls only while a result waits.
// The first press of an armed button queues its code (1, 2, 3 for buttons 0, 1, 2), pushes
// into a full queue are dropped, and a button re-arms once its pin has been low for
// debounce_ms milliseconds. Write debounce_ms only while no item is in flight.
// Depends on bld_pkg, bld_if, bld_lane and bld_fifo.
module button_lockout_debounce_event_fifo
    import bld_pkg::*;
#(
    parameter int FIFO_DEPTH   = 16,
    parameter int BUTTON_COUNT = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DEB_W-1:0]   cfg_wdata,
    bld_in_if.sink             item,
    bld_out_if.source          result
);

    logic [DEB_W-1:0]         debounce_reg;
    logic                     accept;
    logic [BUTTON_COUNT-1:0]  push_req;
    fifo_res_t                fifo_res;
    logic                     valid_reg;
    logic                     valid_next;
    evt_code_t                code_reg;
    logic [QCNT_W-1:0]        count_reg;

    assign item.ready = ~valid_reg | result.ready;
    assign accept     = item.valid & item.ready;
    assign valid_next = accept | (valid_reg & ~result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    for (genvar g = 0; g < BUTTON_COUNT; g++)
    begin : g_lane
        logic rise;
        logic pin;

        if (g < PIN_W)
        begin : g_pin
            assign rise = item.rising_edges[g];
            assign pin  = item.pin_levels[g];
        end
        else
        begin : g_nopin
            assign rise = 1'b0;
            assign pin  = 1'b0;
        end

        bld_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (accept),
            .rise        (rise),
            .pin         (pin),
            .now_ms      (item.now_ms),
            .debounce_ms (debounce_reg),
            .push_req    (push_req[g])
        );
    end

    bld_fifo #(
        .DEPTH (FIFO_DEPTH),
        .LANES (BUTTON_COUNT)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .push_req (push_req),
        .pop      (item.pop_request),
        .res      (fifo_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= fifo_res.event_code;
            count_reg <= fifo_res.queued_count;
        end
    end

    assign result.valid        = valid_reg;
    assign result.event_code   = code_reg;
    assign result.queued_count = count_reg;

endmodule

[design/bld_checker.sv]
// Port-level checker for the button debouncer, attached to the top level by a bind.
// Depends on bld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bld_checker
    import bld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [EVT_W-1:0]   event_code,
    input  logic [QCNT_W-1:0]  queued_count
);

    `ASSERT_ALWAYS(a_no_word_in_reset, !rst_n |-> !out_valid)
    `ASSERT_CLK(a_accept_gives_word, (in_valid && in_ready) |=> out_valid)
    `ASSERT_CLK(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready)
    `ASSERT_CLK(a_stall_holds_word,
        (out_valid && !out_ready) |=> (out_valid && $stable(event_code)
        && $stable(queued_count)))

endmodule

bind button_lockout_debounce_event_fifo bld_checker u_bld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .event_code   (result.event_code),
    .queued_count (result.queued_count)
);

[test/button_lockout_debounce_event_fifo_test.sv]
// Self-checking testbench for the three-button lockout debouncer with its event queue.
// Drives words through bld_in_if, predicts every result word and checks it from bld_out_if.
// Depends on bld_pkg, bld_if and the button_lockout_debounce_event_fifo RTL.
`timescale 1ns / 1ps

module button_lockout_debounce_event_fifo_test;
    import bld_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEYS = 3;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic [PIN_W-1:0]  edges;
        logic [PIN_W-1:0]  pins;
        logic [TIME_W-1:0] stamp;
        logic              pop;
    } press_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [DEB_W-1:0] cfg_wdata;

    bld_in_if item_ch ();
    bld_out_if result_ch ();

    button_lockout_debounce_event_fifo DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    press_word_t pending_words[$];
    fifo_res_t expected_events[$];

    // Debouncer and queue state as the block should hold it.
    logic [DEB_W-1:0]  debounce_model = DEBOUNCE_RESET;
    logic              armed_model [KEYS];
    logic [TIME_W-1:0] last_high_model [KEYS];
    evt_code_t         store_model [QUEUE_DEPTH];
    logic [4:0]        wr_ptr_model;
    logic [4:0]        rd_ptr_model;

    logic mismatch_seen;
    logic steady;
    int   send_gap;
    int   hold_cnt;
    int   results_seen;
    logic long_stall_done;
    int   stuck_cycles;

    always #6 clk = ~clk;

    function automatic evt_code_t button_code(input int idx);
        case (idx)
            0: return EVT_PAGE;
            1: return EVT_TRIGGER0;
            default: return EVT_TRIGGER1;
        endcase
    endfunction

    task automatic debounce_step(input press_word_t w);
        fifo_res_t res;
        logic [TIME_W-1:0] elapsed;
        begin
            res.event_code = EVT_NONE;
            for (int i = 0; i < KEYS; i++)
            begin
                if (w.edges[i] && armed_model[i])
                begin
                    armed_model[i] = 1'b0;
                    if (5'(wr_ptr_model - rd_ptr_model) < QUEUE_DEPTH)
                    begin
                        store_model[wr_ptr_model[3:0]] = button_code(i);
                        wr_ptr_model = wr_ptr_model + 5'd1;
                    end
                end
            end
            for (int i = 0; i < KEYS; i++)
            begin
                if (!armed_model[i])
                begin
                    elapsed = w.stamp - last_high_model[i];
                    if (w.pins[i])
                        last_high_model[i] = w.stamp;
                    else if (elapsed >= {16'd0, debounce_model})
                        armed_model[i] = 1'b1;
                end
            end
            if (w.pop && wr_ptr_model != rd_ptr_model)
            begin
                res.event_code = store_model[rd_ptr_model[3:0]];
                rd_ptr_model = rd_ptr_model + 5'd1;
            end
            res.queued_count = wr_ptr_model - rd_ptr_model;
            expected_events.push_back(res);
        end
    endtask

    // Sender side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                debounce_step('{item_ch.rising_edges, item_ch.pin_levels,
                                item_ch.now_ms, item_ch.pop_request});
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    press_word_t w;
                    w = pending_words.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.rising_edges <= w.edges;
                    item_ch.pin_levels <= w.pins;
                    item_ch.now_ms <= w.stamp;
                    item_ch.pop_request <= w.pop;
                    if (!steady && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 13);
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side and result check.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                fifo_res_t exp_res;
                results_seen = results_seen + 1;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected word, event_code %0d queued_count %0d",
                             $realtime, result_ch.event_code, result_ch.queued_count);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    exp_res = expected_events.pop_front();
                    if (result_ch.event_code !== exp_res.event_code)
                    begin
                        $display("%0t: event_code expected %0d actual %0d", $realtime,
                                 exp_res.event_code, result_ch.event_code);
                        mismatch_seen = 1'b1;
                    end
                    if (result_ch.queued_count !== exp_res.queued_count)
                    begin
                        $display("%0t: queued_count expected %0d actual %0d", $realtime,
                                 exp_res.queued_count, result_ch.queued_count);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!long_stall_done && results_seen >= 150)
            begin
                long_stall_done = 1'b1;
                hold_cnt = 79;
                result_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                hold_cnt = $urandom_range(0, 12);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $realtime, STUCK_LIMIT);
                $display("button_lockout_debounce_event_fifo regression: fail");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [2:0] e, input logic [2:0] p,
                              input logic [31:0] t, input logic pop);
        begin
            pending_words.push_back('{e, p, t, pop});
        end
    endtask

    task automatic wait_drained();
        begin
            @(negedge clk);
            while (pending_words.size() != 0 || item_ch.valid || expected_events.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic write_debounce(input logic [DEB_W-1:0] v);
        begin
            wait_drained();
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we <= 1'b0;
            debounce_model = v;
        end
    endtask

    task automatic random_phase(input int count, input int pop_pct, input logic [31:0] start);
        logic [31:0] t;
        logic [2:0] e;
        logic [2:0] p;
        int span;
        int roll;
        begin
            t = start;
            span = debounce_model;
            for (int n = 0; n < count; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    t = t + $urandom_range(0, span / 3 + 1);
                else if (roll < 95)
                    t = t + $urandom_range(span / 2, span + span / 2 + 2);
                else
                    t = $urandom;
                e = $urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : 3'd0;
                for (int i = 0; i < KEYS; i++)
                    p[i] = ($urandom_range(0, 99) < 40);
                queue_word(e, p, t, $urandom_range(0, 99) < pop_pct);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.rising_edges = '0;
        item_ch.pin_levels = '0;
        item_ch.now_ms = '0;
        item_ch.pop_request = 1'b0;
        result_ch.ready = 1'b0;
        mismatch_seen = 1'b0;
        steady = 1'b0;
        send_gap = 0;
        hold_cnt = 0;
        results_seen = 0;
        long_stall_done = 1'b0;
        wr_ptr_model = '0;
        rd_ptr_model = '0;
        for (int i = 0; i < KEYS; i++)
        begin
            armed_model[i] = 1'b1;
            last_high_model[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Presses, lockout, re-arm and timestamp wrap at the reset debounce time.
        queue_word(3'b111, 3'b111, 32'd100, 1'b0);
        queue_word(3'b111, 3'b000, 32'd110, 1'b0);
        queue_word(3'b000, 3'b000, 32'd119, 1'b1);
        queue_word(3'b000, 3'b000, 32'd120, 1'b1);
        queue_word(3'b001, 3'b001, 32'hFFFF_FFF0, 1'b1);
        queue_word(3'b000, 3'b000, 32'h0000_0003, 1'b0);
        queue_word(3'b001, 3'b000, 32'h0000_0004, 1'b1);
        queue_word(3'b000, 3'b000, 32'hFFFF_FFFF, 1'b1);

        // With no debounce time the queue overflows and drops pushes.
        write_debounce(16'd0);
        for (int k = 0; k < 6; k++)
            queue_word(3'b111, 3'b000, 32'(k), 1'b0);
        queue_word(3'b111, 3'b111, 32'd5, 1'b1);
        queue_word(3'b111, 3'b000, 32'd5, 1'b1);

        write_debounce(16'hFFFF);
        queue_word(3'b111, 3'b111, 32'd1000, 1'b0);
        queue_word(3'b000, 3'b000, 32'd66534, 1'b1);
        queue_word(3'b000, 3'b000, 32'd66535, 1'b1);

        write_debounce(16'($urandom_range(1, 40)));
        random_phase(130, 50, $urandom);
        write_debounce(16'hFFFF);
        random_phase(110, 35, 32'hFFFF_0000);
        write_debounce(16'd0);
        random_phase(120, 60, $urandom);
        write_debounce(16'd1);
        random_phase(120, 45, $urandom);
        write_debounce(DEBOUNCE_RESET);
        steady <= 1'b1;
        random_phase(120, 50, $urandom);

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_events.size() != 0)
            $display("%0t: %0d expected words never arrived", $realtime,
                     expected_events.size());
        if (!mismatch_seen && expected_events.size() == 0)
            $display("button_lockout_debounce_event_fifo regression: pass");
        else
            $display("button_lockout_debounce_event_fifo regression: fail");
        $finish;
    end

endmodule
